@@ sv/hrat_pkg.sv @@
// ----------------------------------------------------------------------------
// hrat_pkg
// shared constants and types for the heart rate and acceleration tracker
// ----------------------------------------------------------------------------
package hrat_pkg;

    localparam int DEF_TIME_WIDTH     = 32;
    localparam int DEF_RATE_FRAC_BITS = 8;

    // milliseconds in one minute
    localparam int MS_PER_MIN = 60000;

    localparam int IN_TIME_W  = 32;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int WIN_W      = 7;
    localparam int CNT_W      = 8;
    localparam int TOTAL_W    = 16;
    localparam int AVG_RATE_W = 16;
    localparam int AVG_ACC_W  = 18;

    localparam logic [WIN_W-1:0] WIN_MAX = 7'd64;

    localparam logic [CFG_DATA_W-1:0] MIN_RATE_RST = 8'd40;
    localparam logic [CFG_DATA_W-1:0] MAX_RATE_RST = 8'd200;
    localparam logic [WIN_W-1:0]      WINDOW_RST   = 7'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RATE = 2'd0,
        CFG_MAX_RATE = 2'd1,
        CFG_WINDOW   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ sv/hrat_div.sv @@
// ----------------------------------------------------------------------------
// hrat_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hrat_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic [NUM_W-1:0]   quo,
    output hrat_pkg::div_stat_t stat
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] trial;
    logic             fits;

    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, den_reg};
    assign fits   = ~trial[DEN_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ sv/heart_rate_accel_tracker_core.sv @@
// ----------------------------------------------------------------------------
// heart_rate_accel_tracker_core
// heart rate and rate-change tracker fed by beat timestamps
// ----------------------------------------------------------------------------
// flow: a beat with no usable interval goes from accept straight to the output
//   state; otherwise the rate is divided, and an accepted rate is then averaged
// throughput: one item at a time, held by any output stall, through the shared
//   bit-serial divider (up to three divisions per accepted beat)
// reset: asynchronous active low; clears all tracking state and loads
//   default bounds and window
module heart_rate_accel_tracker_core #(
    parameter int TIME_WIDTH     = hrat_pkg::DEF_TIME_WIDTH,
    parameter int RATE_FRAC_BITS = hrat_pkg::DEF_RATE_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hrat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hrat_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hrat_pkg::IN_TIME_W-1:0]      beat_time_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hrat_pkg::AVG_RATE_W-1:0]     avg_rate,
    output logic                                rate_valid,
    output logic signed [hrat_pkg::AVG_ACC_W-1:0] avg_accel,
    output logic                                accel_valid,
    output logic                                beat_accepted,
    output logic [hrat_pkg::TOTAL_W-1:0]        beat_total
);

    import hrat_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int F  = RATE_FRAC_BITS;
    localparam int RW = F + 8;
    localparam int AW = RW + 1;
    localparam int SW = AW + 8;
    localparam int NW = F + 16;
    localparam logic [NW-1:0] RATE_NUM = NW'(MS_PER_MIN) << F;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATE_GO,
        S_RATE_WAIT,
        S_CHECK,
        S_AVG_MUL,
        S_AVG_GO,
        S_AVG_WAIT,
        S_ACC_MUL,
        S_ACC_GO,
        S_ACC_WAIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] min_reg, min_next;
    logic [CFG_DATA_W-1:0] max_reg, max_next;
    logic [WIN_W-1:0]      win_reg, win_next;

    logic [TW-1:0]         last_reg, last_next;
    logic [TW-1:0]         ival_reg, ival_next;
    logic [NW-1:0]         inst_reg, inst_next;
    logic [RW-1:0]         ravg_reg, ravg_next;
    logic [RW-1:0]         prev_reg, prev_next;
    logic signed [AW-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic                  acpt_reg, acpt_next;
    logic                  neg_reg, neg_next;
    logic [RW+5:0]         prod_reg, prod_next;
    logic signed [SW-1:0]  sprod_reg, sprod_next;

    logic                  ov_reg, ov_next;
    logic [AVG_RATE_W-1:0] o_rate_reg, o_rate_next;
    logic                  o_rv_reg, o_rv_next;
    logic [AVG_ACC_W-1:0]  o_acc_reg, o_acc_next;
    logic                  o_av_reg, o_av_next;
    logic                  o_ba_reg, o_ba_next;
    logic [TOTAL_W-1:0]    o_tot_reg, o_tot_next;

    logic [TW-1:0]         t_in;
    logic [TW-1:0]         ival_in;
    logic [WIN_W-1:0]      w_eff;
    logic [CNT_W-1:0]      two_w;
    logic [WIN_W-1:0]      n_val;
    logic [5:0]            n_m1;
    logic [CNT_W-1:0]      m_raw;
    logic [CNT_W-1:0]      m_val;
    logic [6:0]            m_m1;
    logic [RW-1:0]         inst_rw;
    logic [NW-1:0]         lo_b, hi_b;
    logic signed [SW-1:0]  sum_s;
    logic [SW-1:0]         mag;
    logic [31:0]           rate_ext;
    logic signed [31:0]    acc_ext;

    logic                  div_start;
    logic [NW-1:0]         div_num;
    logic [TW-1:0]         div_den;
    logic [NW-1:0]         div_quo;
    div_stat_t             div_stat;

    hrat_div #(
        .NUM_W (NW),
        .DEN_W (TW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // window clamp and averaging lengths
    always_comb
    begin
        if (win_reg == '0)
            w_eff = WIN_W'(1);
        else if (win_reg > WIN_MAX)
            w_eff = WIN_MAX;
        else
            w_eff = win_reg;
        two_w = {w_eff, 1'b0};
        n_val = (cnt_reg < CNT_W'(w_eff)) ? cnt_reg[WIN_W-1:0] : w_eff;
        if (n_val == '0)
            n_val = WIN_W'(1);
        n_m1  = 6'(n_val - 1'b1);
        m_raw = cnt_reg - 1'b1;
        m_val = (m_raw > two_w) ? two_w : m_raw;
        if (m_val == '0)
            m_val = CNT_W'(1);
        m_m1  = 7'(m_val - 1'b1);
    end

    assign t_in    = TW'(beat_time_ms);
    assign ival_in = t_in - last_reg;
    assign inst_rw = inst_reg[RW-1:0];
    assign lo_b    = NW'(min_reg) << F;
    assign hi_b    = NW'(max_reg) << F;
    assign sum_s   = sprod_reg + $signed({1'b0, inst_rw}) - $signed({1'b0, prev_reg});
    assign mag     = sum_s[SW-1] ? SW'(-sum_s) : SW'(sum_s);

    // divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_num   = RATE_NUM;
        div_den   = ival_reg;
        unique case (state_reg)
            S_RATE_GO:
            begin
                div_start = 1'b1;
            end
            S_AVG_GO:
            begin
                div_start = 1'b1;
                div_num   = NW'(inst_rw) + NW'(prod_reg);
                div_den   = TW'(n_val);
            end
            S_ACC_GO:
            begin
                div_start = 1'b1;
                div_num   = NW'(mag);
                div_den   = TW'(m_val);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        win_next    = win_reg;
        last_next   = last_reg;
        ival_next   = ival_reg;
        inst_next   = inst_reg;
        ravg_next   = ravg_reg;
        prev_next   = prev_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        acpt_next   = acpt_reg;
        neg_next    = neg_reg;
        prod_next   = prod_reg;
        sprod_next  = sprod_reg;
        ov_next     = ov_reg && !out_ready;
        o_rate_next = o_rate_reg;
        o_rv_next   = o_rv_reg;
        o_acc_next  = o_acc_reg;
        o_av_next   = o_av_reg;
        o_ba_next   = o_ba_reg;
        o_tot_next  = o_tot_reg;
        rate_ext    = 32'(ravg_reg);
        acc_ext     = 32'(acc_reg);

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_RATE: min_next = cfg_data;
                CFG_MAX_RATE: max_next = cfg_data;
                CFG_WINDOW:   win_next = cfg_data[WIN_W-1:0];
                default:      ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    acpt_next = 1'b0;
                    last_next = t_in;
                    ival_next = ival_in;
                    if (total_reg != '1)
                        total_next = total_reg + 1'b1;
                    if (last_reg != '0 && ival_in != '0)
                        state_next = S_RATE_GO;
                    else
                        state_next = S_OUT;
                end
            end
            S_RATE_GO:
            begin
                state_next = S_RATE_WAIT;
            end
            S_RATE_WAIT:
            begin
                if (div_stat.done)
                begin
                    inst_next  = div_quo;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (inst_reg > lo_b && inst_reg < hi_b)
                begin
                    acpt_next = 1'b1;
                    if (cnt_reg <= two_w)
                        cnt_next = cnt_reg + 1'b1;
                    state_next = S_AVG_MUL;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_AVG_MUL:
            begin
                prod_next  = ravg_reg * n_m1;
                state_next = S_AVG_GO;
            end
            S_AVG_GO:
            begin
                state_next = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_stat.done)
                begin
                    ravg_next = div_quo[RW-1:0];
                    if (prev_reg != '0)
                    begin
                        state_next = S_ACC_MUL;
                    end
                    else
                    begin
                        prev_next  = inst_rw;
                        state_next = S_OUT;
                    end
                end
            end
            S_ACC_MUL:
            begin
                sprod_next = acc_reg * $signed({1'b0, m_m1});
                state_next = S_ACC_GO;
            end
            S_ACC_GO:
            begin
                neg_next   = sum_s[SW-1];
                prev_next  = inst_rw;
                state_next = S_ACC_WAIT;
            end
            S_ACC_WAIT:
            begin
                if (div_stat.done)
                begin
                    acc_next   = neg_reg ? -$signed(AW'(div_quo[RW-1:0]))
                                         : $signed(AW'(div_quo[RW-1:0]));
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next     = 1'b1;
                    o_rate_next = (rate_ext > 32'h0000_FFFF) ? '1 : rate_ext[15:0];
                    o_rv_next   = (cnt_reg >= CNT_W'(1));
                    o_acc_next  = acc_ext[AVG_ACC_W-1:0];
                    o_av_next   = (cnt_reg >= CNT_W'(2));
                    o_ba_next   = acpt_reg;
                    o_tot_next  = total_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            min_reg   <= MIN_RATE_RST;
            max_reg   <= MAX_RATE_RST;
            win_reg   <= WINDOW_RST;
            last_reg  <= '0;
            ravg_reg  <= '0;
            prev_reg  <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            total_reg <= '0;
            acpt_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            win_reg   <= win_next;
            last_reg  <= last_next;
            ravg_reg  <= ravg_next;
            prev_reg  <= prev_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            acpt_reg  <= acpt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ival_reg   <= ival_next;
        inst_reg   <= inst_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        sprod_reg  <= sprod_next;
        o_rate_reg <= o_rate_next;
        o_rv_reg   <= o_rv_next;
        o_acc_reg  <= o_acc_next;
        o_av_reg   <= o_av_next;
        o_ba_reg   <= o_ba_next;
        o_tot_reg  <= o_tot_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = ov_reg;
    assign avg_rate      = o_rate_reg;
    assign rate_valid    = o_rv_reg;
    assign avg_accel     = $signed(o_acc_reg);
    assign accel_valid   = o_av_reg;
    assign beat_accepted = o_ba_reg;
    assign beat_total    = o_tot_reg;

endmodule

@@ sv/hrat_chk.sv @@
// ----------------------------------------------------------------------------
// hrat_chk
// port-level checks for the heart rate and acceleration tracker
// ----------------------------------------------------------------------------
module hrat_chk (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  cfg_we,
    input logic [hrat_pkg::CFG_IDX_W-1:0]        cfg_index,
    input logic [hrat_pkg::CFG_DATA_W-1:0]       cfg_data,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic [hrat_pkg::IN_TIME_W-1:0]        beat_time_ms,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [hrat_pkg::AVG_RATE_W-1:0]       avg_rate,
    input logic                                  rate_valid,
    input logic signed [hrat_pkg::AVG_ACC_W-1:0] avg_accel,
    input logic                                  accel_valid,
    input logic                                  beat_accepted,
    input logic [hrat_pkg::TOTAL_W-1:0]          beat_total
);

    // an accepted item keeps the block busy for the next cycle
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready
    ) else $error("input ready right after an accepted item");

    a_accel_needs_rate: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && accel_valid |-> rate_valid
    ) else $error("acceleration valid without a valid rate");

    a_accepted_has_rate: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && beat_accepted |-> rate_valid && beat_total != '0
    ) else $error("accepted beat without valid rate or beat count");

    a_no_rate_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !rate_valid |-> avg_rate == '0 && avg_accel == '0
    ) else $error("nonzero averages before any accepted rate");

    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(beat_total)
    ) else $error("result item dropped or changed while stalled");

endmodule

bind heart_rate_accel_tracker_core hrat_chk u_hrat_chk (.*);
